>>> hw/rtl/hls_pkg.sv
// hls_pkg: beat types, stage records and constants for the rgb to hls converter
// no dependencies; imported by every module of the converter
`timescale 1ns / 1ps

package hls_pkg;

   // channel widths
   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 9;
   localparam int HUE_NUM_W = 17;
   localparam int SAT_NUM_W = 16;
   localparam int DIFF_W    = 9;
   localparam int SUM_W     = 9;
   localparam int QUO_BITS  = 9;

   // fixed values of the scheme
   localparam logic [HUE_W-1:0]     GREY_HUE   = 9'd180;
   localparam logic [HUE_NUM_W-1:0] HUE_GREEN  = 17'd120;
   localparam logic [HUE_NUM_W-1:0] HUE_BLUE   = 17'd240;
   localparam logic [HUE_NUM_W-1:0] HUE_WRAP   = 17'd360;
   localparam logic [SUM_W-1:0]     SUM_HALF   = 9'd255;
   localparam logic [SUM_W-1:0]     SUM_FULL   = 9'd510;

   // which component is largest, ties to red then green
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // input beat
   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pixel_type;

   // result beat
   typedef struct packed {
      logic [HUE_W-1:0]  hue_out;
      logic [CHAN_W-1:0] sat_out;
      logic [CHAN_W-1:0] light_out;
   } result_type;

   // after the extremes stage
   typedef struct packed {
      sector_type               sector;
      logic signed [DIFF_W-1:0] diff;
      logic [SUM_W-1:0]         sum;
      logic [CHAN_W-1:0]        delta;
   } extreme_type;

   // running state of both long divisions
   typedef struct packed {
      logic [HUE_NUM_W-1:0] hue_rem;
      logic [CHAN_W-1:0]    hue_den;
      logic [HUE_W-1:0]     hue_quo;
      logic [SAT_NUM_W-1:0] sat_rem;
      logic [CHAN_W-1:0]    sat_den;
      logic [CHAN_W-1:0]    sat_quo;
      logic [CHAN_W-1:0]    light;
   } divide_type;

endpackage

>>> hw/rtl/hls_extreme.sv
// hls_extreme: first pipeline stage, finds max, min, sector and the hue difference
// depends on hls_pkg
`timescale 1ns / 1ps

module hls_extreme
   import hls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   output logic        up_ready,
   input  pixel_type   up_data,
   output logic        dn_valid,
   input  logic        dn_ready,
   output extreme_type dn_data
);

   logic        valid_ff;
   extreme_type stage_ff;
   extreme_type stage_in;

   logic [CHAN_W-1:0] r_val, g_val, b_val, mx, mn;
   logic signed [DIFF_W-1:0] r_s, g_s, b_s;

   // sector by largest component, ties to red then green
   always_comb begin
      r_val = up_data.red_in;
      g_val = up_data.green_in;
      b_val = up_data.blue_in;
      r_s = $signed({1'b0, r_val});
      g_s = $signed({1'b0, g_val});
      b_s = $signed({1'b0, b_val});
      mn = (r_val < g_val) ? r_val : g_val;
      if (b_val < mn) begin
         mn = b_val;
      end
      if (r_val >= g_val && r_val >= b_val) begin
         mx = r_val;
         stage_in.sector = SECT_RED;
         stage_in.diff = g_s - b_s;
      end else if (g_val >= b_val) begin
         mx = g_val;
         stage_in.sector = SECT_GREEN;
         stage_in.diff = b_s - r_s;
      end else begin
         mx = b_val;
         stage_in.sector = SECT_BLUE;
         stage_in.diff = r_s - g_s;
      end
      stage_in.sum = {1'b0, mx} + {1'b0, mn};
      stage_in.delta = mx - mn;
   end

   // stage register with bubble fill
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

>>> hw/rtl/hls_operand.sv
// hls_operand: second pipeline stage, forms dividends, divisors and lightness
// depends on hls_pkg
`timescale 1ns / 1ps

module hls_operand
   import hls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   output logic        up_ready,
   input  extreme_type up_data,
   output logic        dn_valid,
   input  logic        dn_ready,
   output divide_type  dn_data
);

   logic       valid_ff;
   divide_type stage_ff;
   divide_type stage_in;

   logic [HUE_NUM_W-1:0]        delta_w;
   logic [HUE_NUM_W-1:0]        base;
   logic signed [HUE_NUM_W+1:0] diff_x60;
   logic signed [HUE_NUM_W+1:0] hue_num;
   logic [CHAN_W-1:0]           den;
   logic                        grey;

   always_comb begin
      delta_w  = HUE_NUM_W'(up_data.delta);
      grey     = (up_data.delta == '0);
      diff_x60 = (HUE_NUM_W+2)'(up_data.diff) * $signed((HUE_NUM_W+2)'(60));

      // sector base angle times delta, wrap for a negative red hue
      unique case (up_data.sector)
         SECT_RED: begin
            base = (up_data.diff < 0) ? delta_w * HUE_WRAP : '0;
         end
         SECT_GREEN: begin
            base = delta_w * HUE_GREEN;
         end
         SECT_BLUE: begin
            base = delta_w * HUE_BLUE;
         end
         default: begin
            base = '0;
         end
      endcase
      hue_num = $signed({2'b00, base}) + diff_x60;

      // saturation divisor folds at the half-way sum
      if (up_data.sum <= SUM_HALF) begin
         den = up_data.sum[CHAN_W-1:0];
      end else begin
         den = CHAN_W'(SUM_FULL - up_data.sum);
      end

      // grey pixel divides to fixed hue and zero saturation
      if (grey) begin
         stage_in.hue_rem = HUE_NUM_W'(GREY_HUE);
         stage_in.hue_den = CHAN_W'(1);
         stage_in.sat_rem = '0;
         stage_in.sat_den = CHAN_W'(1);
      end else begin
         stage_in.hue_rem = hue_num[HUE_NUM_W-1:0];
         stage_in.hue_den = up_data.delta;
         stage_in.sat_rem = {up_data.delta, CHAN_W'(0)} - SAT_NUM_W'(up_data.delta);
         stage_in.sat_den = den;
      end
      stage_in.hue_quo = '0;
      stage_in.sat_quo = '0;
      stage_in.light   = up_data.sum[SUM_W-1:1];
   end

   // stage register with bubble fill
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

>>> hw/rtl/hls_div_step.sv
// hls_div_step: one restoring division step for hue and saturation, one quotient bit each
// depends on hls_pkg
`timescale 1ns / 1ps

module hls_div_step
   import hls_pkg::*;
#(
   parameter int BIT_POS = 0
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  divide_type up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output divide_type dn_data
);

   logic       valid_ff;
   divide_type stage_ff;
   divide_type stage_in;

   logic [HUE_NUM_W-1:0] hue_sub;
   logic [SAT_NUM_W-1:0] sat_sub;
   logic                 hue_take;
   logic                 sat_take;

   // compare remainder against shifted divisor, subtract on a fit
   always_comb begin
      stage_in = up_data;
      hue_sub  = HUE_NUM_W'(up_data.hue_den) << BIT_POS;
      sat_sub  = SAT_NUM_W'(up_data.sat_den) << BIT_POS;
      hue_take = (up_data.hue_rem >= hue_sub);
      sat_take = (up_data.sat_rem >= sat_sub);
      if (hue_take) begin
         stage_in.hue_rem = up_data.hue_rem - hue_sub;
      end
      if (sat_take) begin
         stage_in.sat_rem = up_data.sat_rem - sat_sub;
      end
      stage_in.hue_quo = {up_data.hue_quo[HUE_W-2:0], hue_take};
      stage_in.sat_quo = {up_data.sat_quo[CHAN_W-2:0], sat_take};
   end

   // stage register with bubble fill
   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

>>> hw/rtl/rgb_to_hls_convert.sv
// Converts one 8-bit RGB pixel per beat into hue in degrees (0..359), saturation and
// lightness (0..255), with truncating integer division throughout; a grey pixel gives
// hue 180 and saturation 0. The block takes one pixel every clock while its results are
// taken at the same pace: two stages find the extremes and form the operands,
// then nine division stages each settle one quotient bit of the hue and of the saturation.
// Every stage holds its beat under backpressure and fills bubbles, so a waiting result
// stops new pixels only once all eleven stages hold a beat; ready runs combinationally
// from the result port back to the pixel port. Depends on hls_pkg, hls_extreme,
// hls_operand and hls_div_step.
`timescale 1ns / 1ps

module rgb_to_hls_convert
   import hls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  pixel_type  req_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   extreme_type ext_data;
   logic        ext_valid;
   logic        ext_ready;

   logic       div_valid [QUO_BITS+1];
   logic       div_ready [QUO_BITS+1];
   divide_type div_data  [QUO_BITS+1];

   // extremes and sector
   hls_extreme u_extreme (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_pixel),
      .dn_valid (ext_valid),
      .dn_ready (ext_ready),
      .dn_data  (ext_data)
   );

   // dividends, divisors and lightness
   hls_operand u_operand (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ext_valid),
      .up_ready (ext_ready),
      .up_data  (ext_data),
      .dn_valid (div_valid[0]),
      .dn_ready (div_ready[0]),
      .dn_data  (div_data[0])
   );

   // division chain, most significant quotient bit first
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      hls_div_step #(
         .BIT_POS (QUO_BITS - 1 - i)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[i]),
         .up_ready (div_ready[i]),
         .up_data  (div_data[i]),
         .dn_valid (div_valid[i+1]),
         .dn_ready (div_ready[i+1]),
         .dn_data  (div_data[i+1])
      );
   end

   // last division stage is the result register
   assign rsp_valid                = div_valid[QUO_BITS];
   assign div_ready[QUO_BITS]      = rsp_ready;
   assign rsp_result.hue_out       = div_data[QUO_BITS].hue_quo;
   assign rsp_result.sat_out       = div_data[QUO_BITS].sat_quo;
   assign rsp_result.light_out     = div_data[QUO_BITS].light;

endmodule
